>>> hdl/aircraft_light_sequencer_defines.svh
// Assertion macros for the aircraft light sequencer.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef AIRCRAFT_LIGHT_SEQUENCER_DEFINES_SVH
`define AIRCRAFT_LIGHT_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define ALS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ALS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/als_pkg.sv
// Shared types and constants for the aircraft light sequencer.
// No dependencies.
package als_pkg;

	localparam int IN_W       = 8;
	localparam int OUT_W      = 80;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int PHASE_W    = 12;

	localparam logic [7:0] LEVEL_FULL = 8'hFF;

	localparam logic [CFG_IDX_W-1:0] REG_TAIL_DIM   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLASH_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLE      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EMERG_HALF = 2'd3;

	localparam logic [7:0]  TAIL_DIM_RST   = 8'd32;
	localparam logic [7:0]  FLASH_STEP_RST = 8'd40;
	localparam logic [11:0] CYCLE_RST      = 12'd1000;
	localparam logic [10:0] EMERG_HALF_RST = 11'd250;

	// cabin in bit 0
	typedef struct packed {
		logic emergency;
		logic landing;
		logic strobe;
		logic nav;
		logic cabin;
	} sw_t;

	// red in the lowest byte
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	typedef struct packed {
		logic [5:0] pad;
		logic       cabin_on;
		logic       landing_overlay;
		rgb_t       tail;
		rgb_t       right;
		rgb_t       left;
	} res_t;

endpackage

>>> hdl/aircraft_light_sequencer.sv
// Aircraft light sequencer top level: tick register, phase logic, result register.
// Depends on als_pkg and aircraft_light_sequencer_defines.svh.
//
// channel  | dir | handshake           | payload
// s_*      | in  | s_tvalid / s_tready | s_tdata: one tick word with the five switches
// m_*      | out | m_tvalid / m_tready | m_tdata: light levels, overlay, cabin lamp
// cfg_*    | in  | cfg_wen             | cfg_index, cfg_wdata
//
// Words pass tick, then result register; one word per cycle while m_tready is high.
// The tick register and the result register form a two-entry pipe, so input is
// taken while a result waits. Phase and last switches update as a word moves
// into the result register. Reset loads register defaults and clears the phase.
`include "aircraft_light_sequencer_defines.svh"

module aircraft_light_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [0] cabin_switch, [1] nav_switch, [2] strobe_switch, [3] landing_switch,
	// [4] emergency_switch, [7:5] zero
	input  logic [als_pkg::IN_W-1:0]        s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] left_red, [15:8] left_green, [23:16] left_blue, [31:24] right_red,
	// [39:32] right_green, [47:40] right_blue, [55:48] tail_red,
	// [63:56] tail_green, [71:64] tail_blue, [72] landing_overlay, [73] cabin_on,
	// [79:74] zero
	output logic [als_pkg::OUT_W-1:0]       m_tdata,
	input  logic                            cfg_wen,
	input  logic [als_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [als_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	logic [7:0]  tail_dim_q;
	logic [7:0]  step_q;
	logic [11:0] cycle_q;
	logic [10:0] half_q;

	logic         valid_s1;
	als_pkg::sw_t sw_s1;

	logic          m_valid_q;
	als_pkg::res_t res_q;

	logic [als_pkg::PHASE_W-1:0] phase_q;
	als_pkg::sw_t                last_sw_q;

	logic          adv;
	logic          sw_change;
	logic [11:0]   p;
	logic [11:0]   step12, s2, s4, s5;
	logic [11:0]   emerg_period, norm_period, period;
	logic [12:0]   p_inc;
	logic [11:0]   phase_next;
	logic          wing_flash, tail_flash;
	als_pkg::res_t res_d;

	assign adv      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_dim_q <= als_pkg::TAIL_DIM_RST;
			step_q     <= als_pkg::FLASH_STEP_RST;
			cycle_q    <= als_pkg::CYCLE_RST;
			half_q     <= als_pkg::EMERG_HALF_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				als_pkg::REG_TAIL_DIM:   tail_dim_q <= cfg_wdata[7:0];
				als_pkg::REG_FLASH_STEP: step_q     <= cfg_wdata[7:0];
				als_pkg::REG_CYCLE:      cycle_q    <= cfg_wdata[11:0];
				als_pkg::REG_EMERG_HALF: half_q     <= cfg_wdata[10:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sw_s1 <= als_pkg::sw_t'(s_tdata[4:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			phase_q   <= '0;
			last_sw_q <= '0;
		end else begin
			if (adv) begin
				m_valid_q <= 1'b1;
				phase_q   <= phase_next;
				last_sw_q <= sw_s1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	always_comb begin
		sw_change    = sw_s1 != last_sw_q;
		p            = sw_change ? 12'd0 : phase_q;
		step12       = {4'd0, step_q};
		s2           = step12 << 1;
		s4           = step12 << 2;
		s5           = s4 + step12;
		emerg_period = {half_q, 1'b0};
		norm_period  = (cycle_q < s5) ? s5 : cycle_q;
		period       = sw_s1.emergency ? emerg_period : norm_period;
		p_inc        = {1'b0, p} + 13'd1;
		phase_next   = (p_inc >= {1'b0, period}) ? 12'd0 : p_inc[11:0];
		wing_flash   = sw_s1.strobe && ((p < step12) || (p >= s2 && p < s4));
		tail_flash   = sw_s1.strobe && (p >= s4) && (p < s5);

		res_d = '0;
		if (sw_s1.emergency) begin
			if (p < {1'b0, half_q}) begin
				res_d.left.red  = als_pkg::LEVEL_FULL;
				res_d.right.red = als_pkg::LEVEL_FULL;
				res_d.tail.red  = als_pkg::LEVEL_FULL;
				res_d.cabin_on  = 1'b1;
			end
		end else begin
			if (wing_flash) begin
				res_d.left  = '{blue: als_pkg::LEVEL_FULL, green: als_pkg::LEVEL_FULL,
					red: als_pkg::LEVEL_FULL};
				res_d.right = res_d.left;
			end else begin
				if (sw_s1.nav) begin
					res_d.left.red    = als_pkg::LEVEL_FULL;
					res_d.right.green = als_pkg::LEVEL_FULL;
				end
				res_d.landing_overlay = sw_s1.landing;
			end
			if (tail_flash) begin
				res_d.tail = '{blue: als_pkg::LEVEL_FULL, green: als_pkg::LEVEL_FULL,
					red: als_pkg::LEVEL_FULL};
			end else if (sw_s1.nav) begin
				res_d.tail = '{blue: tail_dim_q, green: tail_dim_q, red: tail_dim_q};
			end
			res_d.cabin_on = sw_s1.cabin;
		end
	end

	`ALS_ASSERT_NEXT(a_restart, adv && sw_change, phase_q <= 12'd1,
		"phase did not restart on switch change")
	`ALS_ASSERT_NEXT(a_hold_phase, !adv, $stable(phase_q) && $stable(last_sw_q),
		"phase moved without a word")
	`ALS_ASSERT_NEXT(a_keep_s1, valid_s1 && m_valid_q && !m_tready, valid_s1,
		"stalled word lost from tick register")
	`ALS_ASSERT_NEXT(a_emerg_on, adv && sw_s1.emergency && p < {1'b0, half_q},
		res_q.cabin_on && res_q.tail.red == als_pkg::LEVEL_FULL,
		"emergency on-phase not red")
	`ALS_ASSERT_NOW(a_overlay, m_valid_q && res_q.landing_overlay,
		res_q.left.green == 8'd0 && res_q.left.blue == 8'd0,
		"landing overlay over white wing")

endmodule
